// ----- sv/tsrq_pkg.sv -----
`timescale 1ns / 1ps

package tsrq_pkg;

    localparam int CNT_W     = 9;
    localparam int CFG_W     = 28;
    localparam int CFG_IDX_W = 2;

    // request codes
    localparam logic [2:0] REQ_ENQUEUE = 3'd0;
    localparam logic [2:0] REQ_DEQUEUE = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_FLUSH   = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // flow events
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_STOP = 2'd1;
    localparam logic [1:0] EV_GO   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME_THR = 2'd1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] segment_handle;
        logic [15:0] segment_len;
        logic [31:0] seq_number;
        logic [7:0]  backup_rank;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      out_handle;
        logic [15:0]      out_len;
        logic [31:0]      out_seq;
        logic [1:0]       flow_event;
        logic             flow_stopped;
        logic [CNT_W-1:0] pending_count;
        logic [CNT_W-1:0] backup_count;
        logic [CNT_W-1:0] released_count;
    } out_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_more;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- sv/tsrq_ram.sv -----
`timescale 1ns / 1ps

module tsrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tsrq_ctrl.sv -----
`timescale 1ns / 1ps

module tsrq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tsrq_pkg::dp_stat_t    stat,
    output tsrq_pkg::ctrl_cmd_t   cmd
);

    import tsrq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!stat.walk_more && stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                // release walks one backup entry per cycle before finishing
                cmd.step   = stat.walk_more;
                cmd.finish = !stat.walk_more && stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/tsrq_datapath.sv -----
`timescale 1ns / 1ps

module tsrq_datapath #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tsrq_pkg::ctrl_cmd_t                 cmd,
    output tsrq_pkg::dp_stat_t                  stat,
    input  tsrq_pkg::in_t                       s_data,
    output tsrq_pkg::out_t                      m_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                cfg_wr_en,
    input  logic [tsrq_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [tsrq_pkg::CFG_W-1:0]          cfg_wdata
);

    import tsrq_pkg::*;

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int PW = SW + 1;
    localparam int CW = (PW > 8) ? PW : 8;
    localparam logic [PW-1:0] DEPTH_P = PW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_TOP = PW'(2 * QUEUE_DEPTH - 1);
    localparam logic [PW:0]   TWO_D   = (PW + 1)'(2 * QUEUE_DEPTH);
    localparam logic [CW:0]   DEPTH_C = (CW + 1)'(QUEUE_DEPTH);

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PTR_TOP) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEPTH_P) ? p - DEPTH_P : p;
        return s[SW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_span(input logic [PW-1:0] from,
                                               input logic [PW-1:0] to);
        logic [PW:0] wrapped;
        wrapped = {1'b0, to} + TWO_D - {1'b0, from};
        return (to >= from) ? to - from : wrapped[PW-1:0];
    endfunction

    // state
    in_t              req_reg;
    logic [PW-1:0]    bh_reg, ph_reg, pt_reg;
    logic [PW-1:0]    bh_next, ph_next, pt_next;
    logic [31:0]      ob_reg, ob_next;
    logic             stopped_reg, stopped_next;
    logic [CFG_W-1:0] stop_thr_reg, resume_thr_reg;
    logic [PW-1:0]    rel_cnt_reg;
    out_t             out_reg;
    out_t             res;
    logic             m_valid_reg;

    // store access
    logic [SW-1:0]    rank_slot;
    logic [CW:0]      rank_sum, rank_wrap;
    logic             data_we, tag_we;
    logic [SW-1:0]    data_raddr, tag_raddr;
    logic [47:0]      data_rdata;
    logic [31:0]      tag_rdata;
    logic [31:0]      data_handle;
    logic [15:0]      rd_len;

    logic [PW-1:0]    pend, back, total;
    logic [32:0]      enq_sum;

    assign rank_sum  = (CW + 1)'(ptr_slot(bh_reg)) + (CW + 1)'(s_data.backup_rank);
    assign rank_wrap = (rank_sum >= DEPTH_C) ? rank_sum - DEPTH_C : rank_sum;
    assign rank_slot = rank_wrap[SW-1:0];

    assign data_raddr = (s_data.req_type == REQ_READ) ? rank_slot : ptr_slot(ph_reg);
    assign tag_raddr  = cmd.step ? ptr_slot(ptr_next(bh_reg)) :
                        (s_data.req_type == REQ_READ) ? rank_slot : ptr_slot(bh_reg);

    assign data_handle = data_rdata[47:16];
    assign rd_len      = data_rdata[15:0];

    tsrq_ram #(
        .WIDTH (48),
        .DEPTH (QUEUE_DEPTH)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (data_we && cmd.finish),
        .waddr (ptr_slot(pt_reg)),
        .wdata ({req_reg.segment_handle, req_reg.segment_len}),
        .re    (cmd.capture),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    tsrq_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we && cmd.finish),
        .waddr (ptr_slot(ph_reg)),
        .wdata (req_reg.seq_number),
        .re    (cmd.capture || cmd.step),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    assign pend  = ptr_span(ph_reg, pt_reg);
    assign back  = ptr_span(bh_reg, ph_reg);
    assign total = ptr_span(bh_reg, pt_reg);

    assign enq_sum = {1'b0, ob_reg} + 33'(req_reg.segment_len);

    assign stat.walk_more = (req_reg.req_type == REQ_RELEASE) && (bh_reg != ph_reg)
                            && (tag_rdata < req_reg.seq_number);
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        bh_next      = bh_reg;
        ph_next      = ph_reg;
        pt_next      = pt_reg;
        ob_next      = ob_reg;
        stopped_next = stopped_reg;
        data_we      = 1'b0;
        tag_we       = 1'b0;
        res          = '0;
        case (req_reg.req_type)
            REQ_ENQUEUE: begin
                if (total >= DEPTH_P) begin
                    res.status = STAT_FULL;
                end else begin
                    data_we = 1'b1;
                    pt_next = ptr_next(pt_reg);
                    ob_next = enq_sum[32] ? '1 : enq_sum[31:0];
                    if (ob_next > 32'(stop_thr_reg) && !stopped_reg) begin
                        stopped_next   = 1'b1;
                        res.flow_event = EV_STOP;
                    end
                end
            end
            REQ_DEQUEUE: begin
                if (pend == '0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    tag_we         = 1'b1;
                    res.out_handle = data_handle;
                    res.out_len    = rd_len;
                    ph_next        = ptr_next(ph_reg);
                    ob_next        = (ob_reg < 32'(rd_len)) ? '0 : ob_reg - 32'(rd_len);
                    if (ob_next < 32'(resume_thr_reg) && stopped_reg) begin
                        stopped_next   = 1'b0;
                        res.flow_event = EV_GO;
                    end
                end
            end
            REQ_READ: begin
                if (CW'(req_reg.backup_rank) >= CW'(back)) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.out_handle = data_handle;
                    res.out_len    = rd_len;
                    res.out_seq    = tag_rdata;
                end
            end
            REQ_RELEASE: begin
                res.released_count = CNT_W'(rel_cnt_reg);
            end
            REQ_FLUSH: begin
                res.released_count = CNT_W'(total);
                bh_next            = pt_reg;
                ph_next            = pt_reg;
            end
            default: ;
        endcase
        res.flow_stopped  = stopped_next;
        res.pending_count = CNT_W'(ptr_span(ph_next, pt_next));
        res.backup_count  = CNT_W'(ptr_span(bh_next, ph_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bh_reg         <= '0;
            ph_reg         <= '0;
            pt_reg         <= '0;
            ob_reg         <= '0;
            stopped_reg    <= 1'b0;
            stop_thr_reg   <= CFG_W'(3000000);
            resume_thr_reg <= CFG_W'(2000000);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_STOP_THR:   stop_thr_reg   <= cfg_wdata;
                    CFG_RESUME_THR: resume_thr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.step) begin
                bh_reg <= ptr_next(bh_reg);
            end
            if (cmd.finish) begin
                bh_reg      <= bh_next;
                ph_reg      <= ph_next;
                pt_reg      <= pt_next;
                ob_reg      <= ob_next;
                stopped_reg <= stopped_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg     <= s_data;
            rel_cnt_reg <= '0;
        end else if (cmd.step) begin
            rel_cnt_reg <= rel_cnt_reg + PW'(1);
        end
        if (cmd.finish) begin
            out_reg <= res;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

endmodule

// ----- sv/tcp_segment_retransmit_queue.sv -----
`timescale 1ns / 1ps
// channel   ports                        carries
// input     s_valid / s_ready / s_data   one request item (tsrq_pkg::in_t)
// result    m_valid / m_ready / m_data   one result item per request (tsrq_pkg::out_t)
// config    cfg_wr_en / cfg_addr / cfg_wdata   threshold writes, no wait
//
// an item is accepted (store read issued), then executed and loaded into the output
// register; release also walks the freed backup entries one at a time through the tag ram read port
// the next item is accepted while a result waits; execute holds until the output is free
// reset (aresetn low, synchronous) empties both queues; stores need no clearing pass

module tcp_segment_retransmit_queue #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tsrq_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tsrq_pkg::out_t                   m_data,
    input  logic                             cfg_wr_en,
    input  logic [tsrq_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tsrq_pkg::CFG_W-1:0]       cfg_wdata
);

    import tsrq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    tsrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tsrq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tsrq_pkg::*;

    localparam int DEPTH         = 256;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SQUEEZE_AFTER = 150;
    localparam int SQUEEZE_LEN   = 300;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // shadow copy of the segment store and its pointers
    logic [31:0]      shadow_handle [DEPTH];
    logic [15:0]      shadow_len    [DEPTH];
    logic [31:0]      shadow_tag    [DEPTH];
    logic [8:0]       shadow_bk_head = '0;
    logic [8:0]       shadow_pd_head = '0;
    logic [8:0]       shadow_pd_tail = '0;
    logic [31:0]      shadow_bytes   = '0;
    logic             shadow_stopped = 1'b0;
    logic [CFG_W-1:0] stop_thr       = 28'd3000000;
    logic [CFG_W-1:0] resume_thr     = 28'd2000000;

    in_t  req_queue[$];
    out_t reply_queue[$];

    int          bad_fields    = 0;
    int          replies_seen  = 0;
    int          quiet_cycles  = 0;
    int          send_gap      = 0;
    int          send_burst    = 0;
    int          recv_hold     = 0;
    int          recv_burst    = 0;
    bit          squeeze_done  = 1'b0;
    bit          in_taken      = 1'b0;
    logic [31:0] seq_cursor    = '0;

    tcp_segment_retransmit_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_t apply_request(in_t rq);
        out_t       r;
        logic [8:0] pend;
        logic [8:0] back;
        logic [8:0] walk;
        logic [7:0] slot;
        logic [32:0] sum;
        r = '0;
        pend = shadow_pd_tail - shadow_pd_head;
        back = shadow_pd_head - shadow_bk_head;
        case (rq.req_type)
            REQ_ENQUEUE: begin
                if (pend + back >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    slot = shadow_pd_tail[7:0];
                    shadow_handle[slot] = rq.segment_handle;
                    shadow_len[slot] = rq.segment_len;
                    shadow_tag[slot] = '0;
                    shadow_pd_tail = shadow_pd_tail + 9'd1;
                    sum = {1'b0, shadow_bytes} + rq.segment_len;
                    shadow_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (shadow_bytes > {4'd0, stop_thr} && !shadow_stopped) begin
                        shadow_stopped = 1'b1;
                        r.flow_event = EV_STOP;
                    end
                end
            end
            REQ_DEQUEUE: begin
                if (pend == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    slot = shadow_pd_head[7:0];
                    r.out_handle = shadow_handle[slot];
                    r.out_len = shadow_len[slot];
                    shadow_tag[slot] = rq.seq_number;
                    shadow_pd_head = shadow_pd_head + 9'd1;
                    if (shadow_bytes < r.out_len)
                        shadow_bytes = '0;
                    else
                        shadow_bytes = shadow_bytes - r.out_len;
                    if (shadow_bytes < {4'd0, resume_thr} && shadow_stopped) begin
                        shadow_stopped = 1'b0;
                        r.flow_event = EV_GO;
                    end
                end
            end
            REQ_READ: begin
                if ({1'b0, rq.backup_rank} >= back) begin
                    r.status = STAT_EMPTY;
                end else begin
                    walk = shadow_bk_head + rq.backup_rank;
                    r.out_handle = shadow_handle[walk[7:0]];
                    r.out_len = shadow_len[walk[7:0]];
                    r.out_seq = shadow_tag[walk[7:0]];
                end
            end
            REQ_RELEASE: begin
                while (shadow_bk_head != shadow_pd_head &&
                       shadow_tag[shadow_bk_head[7:0]] < rq.seq_number) begin
                    shadow_bk_head = shadow_bk_head + 9'd1;
                    r.released_count = r.released_count + 9'd1;
                end
            end
            REQ_FLUSH: begin
                r.released_count = pend + back;
                shadow_bk_head = shadow_pd_tail;
                shadow_pd_head = shadow_pd_tail;
            end
            default: begin
            end
        endcase
        r.flow_stopped = shadow_stopped;
        r.pending_count = shadow_pd_tail - shadow_pd_head;
        r.backup_count = shadow_pd_head - shadow_bk_head;
        return r;
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap(inout int burst_left);
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t make_req(logic [2:0] kind, logic [31:0] handle, logic [15:0] len,
                                     logic [31:0] seq, logic [7:0] rank);
        in_t rq;
        rq.req_type = kind;
        rq.segment_handle = handle;
        rq.segment_len = len;
        rq.seq_number = seq;
        rq.backup_rank = rank;
        return rq;
    endfunction

    function automatic in_t draw_request(bit fill_mode);
        in_t rq;
        int  roll;
        int  len_roll;
        rq.segment_handle = $urandom();
        rq.seq_number = $urandom();
        rq.backup_rank = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 12));
        len_roll = $urandom_range(0, 7);
        if (len_roll == 0)
            rq.segment_len = '0;
        else if (len_roll == 1)
            rq.segment_len = 16'hFFFF;
        else if (len_roll < 4)
            rq.segment_len = 16'($urandom_range(0, 1500));
        else
            rq.segment_len = 16'($urandom());
        roll = $urandom_range(0, 99);
        if (fill_mode) begin
            if (roll < 86)      rq.req_type = REQ_ENQUEUE;
            else if (roll < 93) rq.req_type = REQ_DEQUEUE;
            else                rq.req_type = REQ_READ;
        end else begin
            if (roll < 35)      rq.req_type = REQ_ENQUEUE;
            else if (roll < 60) rq.req_type = REQ_DEQUEUE;
            else if (roll < 74) rq.req_type = REQ_READ;
            else if (roll < 88) rq.req_type = REQ_RELEASE;
            else if (roll < 92) rq.req_type = REQ_FLUSH;
            else                rq.req_type = REQ_FLUSH + 3'($urandom_range(1, 3));
        end
        // tags climb like sequence numbers so that acks release a prefix
        if (rq.req_type == REQ_DEQUEUE) begin
            seq_cursor = seq_cursor + $urandom_range(1, 3000);
            if ($urandom_range(0, 9) != 0)
                rq.seq_number = seq_cursor;
        end else if (rq.req_type == REQ_RELEASE) begin
            if ($urandom_range(0, 7) != 0)
                rq.seq_number = seq_cursor - $urandom_range(0, 20000);
        end
        return rq;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == CFG_STOP_THR)
            stop_thr = val;
        else if (idx == CFG_RESUME_THR)
            resume_thr = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (req_queue.size() != 0 || s_valid || reply_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] stop_val, logic [CFG_W-1:0] resume_val,
                             int count, bit fill_mode);
        wait_idle();
        write_reg(CFG_STOP_THR, stop_val);
        write_reg(CFG_RESUME_THR, resume_val);
        repeat (count) req_queue.push_back(draw_request(fill_mode));
    endtask

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (bad_fields < 10)
                $display("mismatch on %s at result %0d: expected %0h, got %0h",
                         name, replies_seen, want, got);
            bad_fields++;
        end
    endtask

    // capture accepted items and results
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                reply_queue.push_back(apply_request(s_data));
                in_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (reply_queue.size() == 0) begin
                    if (bad_fields < 10)
                        $display("result with nothing expected: %0h", m_data);
                    bad_fields++;
                end else begin
                    want = reply_queue.pop_front();
                    cmp_field("status", want.status, m_data.status);
                    cmp_field("out_handle", want.out_handle, m_data.out_handle);
                    cmp_field("out_len", want.out_len, m_data.out_len);
                    cmp_field("out_seq", want.out_seq, m_data.out_seq);
                    cmp_field("flow_event", want.flow_event, m_data.flow_event);
                    cmp_field("flow_stopped", want.flow_stopped, m_data.flow_stopped);
                    cmp_field("pending_count", want.pending_count, m_data.pending_count);
                    cmp_field("backup_count", want.backup_count, m_data.backup_count);
                    cmp_field("released_count", want.released_count,
                              m_data.released_count);
                end
                replies_seen++;
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the item until it is taken
        end else if (send_gap > 0) begin
            send_gap--;
            s_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
            s_data  <= req_queue.pop_front();
            s_valid <= 1'b1;
            send_gap = pick_gap(send_burst);
        end else begin
            s_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // receiver, with one long hold-off so the block backs up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!squeeze_done && replies_seen >= SQUEEZE_AFTER) begin
                recv_hold = SQUEEZE_LEN;
                squeeze_done = 1'b1;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_hold = pick_gap(recv_burst);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] thr;
        seq_cursor = $urandom();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty queues, unknown requests, field extremes, ack bounds
        req_queue.push_back(make_req(REQ_DEQUEUE, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_READ, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_RELEASE, '0, '0, 32'hFFFF_FFFF, '0));
        req_queue.push_back(make_req(REQ_FLUSH, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_FLUSH + 3'd1, $urandom(), 16'($urandom()),
                                     $urandom(), 8'($urandom())));
        req_queue.push_back(make_req(REQ_FLUSH + 3'd2, $urandom(), 16'($urandom()),
                                     $urandom(), 8'($urandom())));
        req_queue.push_back(make_req(REQ_FLUSH + 3'd3, 32'hFFFF_FFFF, 16'hFFFF,
                                     32'hFFFF_FFFF, 8'hFF));
        req_queue.push_back(make_req(REQ_ENQUEUE, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, '0, '0));
        req_queue.push_back(make_req(REQ_ENQUEUE, $urandom(), 16'($urandom()), '0, '0));
        req_queue.push_back(make_req(REQ_ENQUEUE, $urandom(), 16'd1, '0, '0));
        req_queue.push_back(make_req(REQ_READ, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_DEQUEUE, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_DEQUEUE, '0, '0, 32'hFFFF_FFFF, '0));
        req_queue.push_back(make_req(REQ_DEQUEUE, '0, '0, 32'd5, '0));
        req_queue.push_back(make_req(REQ_READ, '0, '0, '0, 8'd0));
        req_queue.push_back(make_req(REQ_READ, '0, '0, '0, 8'd2));
        req_queue.push_back(make_req(REQ_READ, '0, '0, '0, 8'd3));
        req_queue.push_back(make_req(REQ_READ, '0, '0, '0, 8'hFF));
        req_queue.push_back(make_req(REQ_RELEASE, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_RELEASE, '0, '0, 32'd1, '0));
        req_queue.push_back(make_req(REQ_RELEASE, '0, '0, 32'hFFFF_FFFF, '0));
        req_queue.push_back(make_req(REQ_FLUSH, '0, '0, '0, '0));
        req_queue.push_back(make_req(REQ_DEQUEUE, '0, '0, '0, '0));

        run_phase('0, '0, 30, 1'b0);
        run_phase('1, '1, 30, 1'b0);
        // enqueue heavy: reaches a full store, thresholds low enough to toggle flow
        run_phase(28'd150000, 28'd60000, 300, 1'b1);
        thr = CFG_W'($urandom_range(0, 300000));
        run_phase(thr, CFG_W'($urandom_range(0, thr)), 30, 1'b0);
        // inverted hysteresis
        thr = CFG_W'($urandom_range(0, 100000));
        run_phase(thr, CFG_W'($urandom_range(thr, 400000)), 30, 1'b0);

        while (req_queue.size() != 0 || s_valid || reply_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_fields == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
